// ===== rtl/rvms_pkg.sv =====
// ----------------------------------------------------------------------------
// rvms_pkg
// Shared widths, register map and defaults of the rolling variance core.
// ----------------------------------------------------------------------------
package rvms_pkg;

	// fixed field widths
	localparam int SMP_W   = 16;
	localparam int VAR_W   = 40;
	localparam int PCNT_W  = 9;
	localparam int CFG_W   = 9;

	// stream payload widths, padded to whole bytes
	localparam int S_DATA_W = ((SMP_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((VAR_W + PCNT_W + 7) / 8) * 8;

	// register map
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_WLEN = 1'b0;
	localparam logic REG_MINC = 1'b1;

	localparam logic [CFG_W-1:0] WLEN_RST = 9'd16;
	localparam logic [CFG_W-1:0] MINC_RST = 9'd0;

	// parameter defaults
	localparam int WINDOW_MAX_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;

endpackage

// ===== rtl/rvms_div.sv =====
// ----------------------------------------------------------------------------
// rvms_div
// Bit-serial restoring divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module rvms_div import rvms_pkg::*; #(
	parameter int DVD_W = 63,
	parameter int DEN_W = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [VAR_W-1:0] quotient
);

	localparam int QW    = (DVD_W > VAR_W) ? DVD_W : VAR_W + 1;
	localparam int CTR_W = $clog2(DVD_W + 1);

	typedef enum logic {D_IDLE, D_RUN} dstate_t;

	dstate_t          state_q;
	logic [CTR_W-1:0] ctr_q;
	logic             done_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QW-1:0]    quo_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_nx;
	logic             fits;

	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};
	assign rem_nx = fits ? rem_sh - {1'b0, den_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			ctr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			// last quotient bit goes in this cycle
			done_q <= (state_q == D_RUN) && (ctr_q == '0);
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_RUN;
						ctr_q   <= CTR_W'(DVD_W - 1);
					end
				end
				D_RUN: begin
					if (ctr_q == '0) begin
						state_q <= D_IDLE;
					end else begin
						ctr_q <= ctr_q - 1'b1;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			dvd_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == D_RUN) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nx[DEN_W-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = (|quo_q[QW-1:VAR_W]) ? {VAR_W{1'b1}} : quo_q[VAR_W-1:0];

endmodule

// ===== rtl/rolling_variance_missing_skip_core.sv =====
// One item at a time: the next input is accepted only after the result of the last one
// is registered. The bit-serial multiply loop and the restoring divider set the pace.
// Reset: arst_n clears control state and the window; the sample ring is never cleared.
// ----------------------------------------------------------------------------
// rolling_variance_missing_skip_core
// Sliding-window unbiased variance over present samples, bit-serial datapath.
// ----------------------------------------------------------------------------
module rolling_variance_missing_skip_core import rvms_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // sample
	input  logic                s_tuser,  // missing
	input  logic                s_tlast,  // end_of_series
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // variance, present_count, zero pad
	output logic                m_tuser,  // defined
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	localparam int S      = SAMPLE_BITS;
	localparam int AW     = $clog2(WINDOW_MAX);
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int SUM_W  = S + CNT_W;
	localparam int SQ_W   = 2 * S + CNT_W - 1;
	localparam int NUM_W  = SQ_W + CNT_W;
	localparam int PW     = 2 * SUM_W;
	localparam int DEN_W  = 2 * CNT_W;
	localparam int DVD_W  = NUM_W + FRAC_BITS;
	localparam int MCTR_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		S_IDLE, S_NEW, S_OLD, S_LOAD, S_MUL, S_SUB, S_DIV, S_DONE
	} state_t;

	state_t             state_q;

	// configuration
	logic [CFG_W-1:0]   wlen_q;
	logic [CFG_W-1:0]   minc_q;
	logic               cfg_wr;

	// window state
	logic [S:0]         ring [WINDOW_MAX];
	logic [S:0]         rd_q;
	logic [AW-1:0]      wp_q;
	logic [CNT_W-1:0]   fill_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]    sq_q;
	logic [CNT_W-1:0]   cnt_q;

	// item being worked
	logic [S-1:0]       smp_q;
	logic               pres_q;
	logic               eos_q;
	logic               evict_q;

	// serial multiply
	logic [SUM_W-1:0]   mq_q;
	logic [SUM_W-1:0]   mb_q;
	logic [SUM_W-1:0]   mag_op_q;
	logic [SQ_W-1:0]    sq_op_q;
	logic [CNT_W-1:0]   cm1_q;
	logic [NUM_W-1:0]   acc_a_q;
	logic [PW-1:0]      acc_b_q;
	logic [DEN_W-1:0]   acc_d_q;
	logic [MCTR_W-1:0]  mctr_q;
	logic [CNT_W-1:0]   cnt_op_q;
	logic               def_q;

	// result register
	logic               out_valid_q;
	logic [VAR_W-1:0]   out_var_q;
	logic [PCNT_W-1:0]  out_pcnt_q;
	logic               out_def_q;

	logic               in_xfer;
	logic [CNT_W-1:0]   len_eff;
	logic [CMP_W-1:0]   wl_ext;
	logic               evict;
	logic [AW:0]        pos_sum;
	logic [AW-1:0]      rd_pos;
	logic [S-1:0]       smp_in;
	logic [S-1:0]       sqr_in;
	logic signed [2*S-1:0] sqr_p;
	logic [SQ_W-1:0]    sqr_ext;
	logic [SUM_W-1:0]   val_ext;
	logic [SUM_W-1:0]   mag;
	logic               cnt_def;
	logic [PW-1:0]      acc_a_ext;
	logic [NUM_W-1:0]   num;
	logic               div_start;
	logic               div_done;
	logic [VAR_W-1:0]   div_quo;
	logic               out_load;

	assign in_xfer  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_MINC) ? DATA_W'(minc_q) : DATA_W'(wlen_q);

	// effective window length: zero acts as one, large values saturate
	always_comb begin
		wl_ext = CMP_W'(wlen_q);
		if (wl_ext == '0) begin
			len_eff = CNT_W'(1);
		end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
			len_eff = CNT_W'(WINDOW_MAX);
		end else begin
			len_eff = CNT_W'(wlen_q);
		end
	end

	assign evict   = fill_q >= len_eff;
	assign pos_sum = (AW+1)'(wp_q) + (AW+1)'(WINDOW_MAX) - (AW+1)'(len_eff);
	assign rd_pos  = (pos_sum >= (AW+1)'(WINDOW_MAX)) ?
	                 AW'(pos_sum - (AW+1)'(WINDOW_MAX)) : AW'(pos_sum);
	assign smp_in  = S'(s_tdata[SMP_W-1:0]);

	// one squarer shared by the new and the evicted sample
	assign sqr_in  = (state_q == S_NEW) ? smp_q : rd_q[S-1:0];
	assign sqr_p   = $signed(sqr_in) * $signed(sqr_in);
	assign sqr_ext = SQ_W'($unsigned(sqr_p));
	assign val_ext = {{(SUM_W-S){sqr_in[S-1]}}, sqr_in};

	assign mag     = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign cnt_def = (cnt_q >= CNT_W'(2)) && (CMP_W'(cnt_q) >= CMP_W'(minc_q));

	// numerator, clamped at zero
	assign acc_a_ext = PW'(acc_a_q);
	assign num       = (acc_b_q > acc_a_ext) ? '0 : NUM_W'(acc_a_ext - acc_b_q);
	assign div_start = (state_q == S_SUB);

	// result register loads once the previous result has been taken
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RST;
			minc_q <= MINC_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_WLEN) begin
				wlen_q <= pwdata[CFG_W-1:0];
			end else begin
				minc_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	// sample ring, read-before-write
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rd_q       <= ring[rd_pos];
			ring[wp_q] <= {~s_tuser, smp_in};
		end
	end

	// window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			sum_q  <= '0;
			sq_q   <= '0;
			cnt_q  <= '0;
		end else if ((cfg_wr && paddr[2] == REG_WLEN) || (state_q == S_LOAD && eos_q)) begin
			wp_q   <= '0;
			fill_q <= '0;
			sum_q  <= '0;
			sq_q   <= '0;
			cnt_q  <= '0;
		end else if (in_xfer) begin
			wp_q <= (wp_q == AW'(WINDOW_MAX - 1)) ? '0 : wp_q + 1'b1;
			if (!evict) begin
				fill_q <= fill_q + 1'b1;
			end
		end else if (state_q == S_NEW && pres_q) begin
			sum_q <= sum_q + val_ext;
			sq_q  <= sq_q + sqr_ext;
			cnt_q <= cnt_q + 1'b1;
		end else if (state_q == S_OLD && evict_q && rd_q[S]) begin
			sum_q <= sum_q - val_ext;
			sq_q  <= sq_q - sqr_ext;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// item capture and bit-serial products, MSB of the multiplier first
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			smp_q   <= smp_in;
			pres_q  <= ~s_tuser;
			eos_q   <= s_tlast;
			evict_q <= evict;
		end
		if (state_q == S_LOAD) begin
			mq_q     <= SUM_W'(cnt_q);
			mb_q     <= mag;
			mag_op_q <= mag;
			sq_op_q  <= sq_q;
			cm1_q    <= cnt_q - 1'b1;
			acc_a_q  <= '0;
			acc_b_q  <= '0;
			acc_d_q  <= '0;
			cnt_op_q <= cnt_q;
			def_q    <= cnt_def;
		end else if (state_q == S_MUL) begin
			acc_a_q <= (acc_a_q << 1) + (mq_q[SUM_W-1] ? NUM_W'(sq_op_q) : '0);
			acc_d_q <= (acc_d_q << 1) + (mq_q[SUM_W-1] ? DEN_W'(cm1_q) : '0);
			acc_b_q <= (acc_b_q << 1) + (mb_q[SUM_W-1] ? PW'(mag_op_q) : '0);
			mq_q    <= mq_q << 1;
			mb_q    <= mb_q << 1;
		end
	end

	rvms_div #(
		.DVD_W (DVD_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DVD_W'(num) << FRAC_BITS),
		.divisor  (acc_d_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mctr_q      <= '0;
			out_valid_q <= 1'b0;
			out_var_q   <= '0;
			out_pcnt_q  <= '0;
			out_def_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_NEW;
					end
				end
				S_NEW:  state_q <= S_OLD;
				S_OLD:  state_q <= S_LOAD;
				S_LOAD: begin
					mctr_q  <= MCTR_W'(SUM_W - 1);
					state_q <= cnt_def ? S_MUL : S_DONE;
				end
				S_MUL: begin
					if (mctr_q == '0) begin
						state_q <= S_SUB;
					end else begin
						mctr_q <= mctr_q - 1'b1;
					end
				end
				S_SUB:  state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// wait until the previous result has been taken
					if (out_load) begin
						out_var_q   <= def_q ? div_quo : '0;
						out_pcnt_q  <= PCNT_W'(cnt_op_q);
						out_def_q   <= def_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_W'({out_pcnt_q, out_var_q});
	assign m_tuser  = out_def_q;

	a_cnt_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> cnt_q <= fill_q)
		else $error("present count exceeds window fill");

	a_fill_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> fill_q <= len_eff)
		else $error("window fill exceeds window length");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_def_q |-> out_var_q == '0)
		else $error("undefined result carries a nonzero variance");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide phase");

endmodule
